### sv/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned ValueW = 32;
  localparam int unsigned PrioW = 16;
  localparam int unsigned OccW = 5;

  typedef enum logic {
    CmdInsert = 1'b0,
    CmdRemove = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    StInserted  = 2'd0,
    StRemoved   = 2'd1,
    StUnderflow = 2'd2,
    StOverflow  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OpHold   = 2'd0,
    OpInsert = 2'd1,
    OpRemove = 2'd2
  } op_e;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic signed [PrioW-1:0]  prio;
  } entry_t;

  typedef struct packed {
    op_e    op;
    entry_t item;
  } cell_ctrl_t;

endpackage

### sv/spq_cell.sv
// One storage cell of the sorted chain: compares against the new request and shifts.
module spq_cell (
  input  logic              clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic              valid_i,
  input  logic              left_le_i,
  input  spq_pkg::entry_t   left_i,
  input  spq_pkg::entry_t   right_i,
  output spq_pkg::entry_t   entry_o,
  output logic              le_o
);
  import spq_pkg::*;

  entry_t entry_q;
  entry_t entry_d;

  assign le_o = valid_i && (entry_q.prio <= ctrl_i.item.prio);

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      OpInsert: begin
        if (le_o) begin
          entry_d = entry_q;
        end else if (left_le_i) begin
          entry_d = ctrl_i.item;
        end else begin
          entry_d = left_i;
        end
      end
      OpRemove: begin
        entry_d = right_i;
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

### sv/sorted_priority_queue_core.sv
// Top level of the sorted priority queue built as a chain of compare-and-shift cells.
// The result of a request is registered and appears in the cycle after the request is accepted.
// Throughput: one request per cycle while no result is held; every cell compares and shifts in the same cycle.
// A new request enters in the cycle the previous result leaves; a held result stalls the input.
// Reset empties the queue and clears the result valid flag; cell contents and result fields stay undefined.
module sorted_priority_queue_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                cmd_i,
  input  logic signed [spq_pkg::ValueW-1:0]   item_value_i,
  input  logic signed [spq_pkg::PrioW-1:0]    item_priority_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          status_o,
  output logic signed [spq_pkg::ValueW-1:0]   removed_value_o,
  output logic [spq_pkg::OccW-1:0]            occupancy_o
);
  import spq_pkg::*;

  logic [CntW-1:0]         count_q, count_d;
  logic                    out_valid_q, out_valid_d;
  status_e                 status_q, status_d;
  logic signed [ValueW-1:0] removed_q, removed_d;
  logic [OccW-1:0]         occ_q, occ_d;

  logic       accept;
  logic       full;
  logic       empty;
  cell_ctrl_t ctrl;

  entry_t cell_entry [CAPACITY];
  logic   cell_le    [CAPACITY];
  logic   cell_valid [CAPACITY];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CntW'(CAPACITY));
  assign empty      = (count_q == '0);

  always_comb begin
    ctrl.item.value = item_value_i;
    ctrl.item.prio  = item_priority_i;
    ctrl.op         = OpHold;
    count_d         = count_q;
    status_d        = status_q;
    removed_d       = removed_q;
    if (accept) begin
      removed_d = '0;
      if (cmd_i == CmdInsert) begin
        if (full) begin
          status_d = StOverflow;
        end else begin
          ctrl.op  = OpInsert;
          count_d  = count_q + CntW'(1);
          status_d = StInserted;
        end
      end else begin
        if (empty) begin
          status_d = StUnderflow;
        end else begin
          ctrl.op   = OpRemove;
          count_d   = count_q - CntW'(1);
          status_d  = StRemoved;
          removed_d = cell_entry[0].value;
        end
      end
    end
    occ_d       = accept ? OccW'(count_d) : occ_q;
    out_valid_d = accept || (out_valid_q && out_stall_i);
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_entry;
    entry_t right_entry;
    logic   left_le;

    assign cell_valid[i] = (CntW'(i) < count_q);

    if (i == 0) begin : g_head
      assign left_entry = ctrl.item;
      assign left_le    = 1'b1;
    end else begin : g_body
      assign left_entry = cell_entry[i-1];
      assign left_le    = cell_le[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = cell_entry[i];
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .valid_i   (cell_valid[i]),
      .left_le_i (left_le),
      .left_i    (left_entry),
      .right_i   (right_entry),
      .entry_o   (cell_entry[i]),
      .le_o      (cell_le[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    removed_q <= removed_d;
    occ_q     <= occ_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign occupancy_o     = occ_q;

endmodule

### dv/sorted_priority_queue_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the sorted priority queue core with random input gaps and random output stalls.
module sorted_priority_queue_core_test;
  import spq_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomItems = 900;
  localparam int unsigned MaxShown = 10;
  localparam int unsigned HoldCycles = 120;

  // Directed inserts as {value, priority}: extremes, ties and alternating bit patterns.
  localparam logic [ValueW+PrioW-1:0] DirectedInserts [16] = '{
    {32'h7FFF_FFFF, 16'h7FFF}, {32'h8000_0000, 16'h8000}, {32'h0000_0000, 16'h0000},
    {32'hFFFF_FFFF, 16'hFFFF}, {32'h0000_0005, 16'h0000}, {32'h0000_0006, 16'h0000},
    {32'h0000_0007, 16'h8000}, {32'h0000_0008, 16'h7FFF}, {32'h0000_0009, 16'h0001},
    {32'h0000_000A, 16'hFFFE}, {32'h0000_000B, 16'h0000}, {32'h0000_000C, 16'h8001},
    {32'h0000_000D, 16'h7FFE}, {32'hAAAA_AAAA, 16'h5555}, {32'h5555_5555, 16'hAAAA},
    {32'h0000_000E, 16'h0000}
  };

  typedef struct {
    cmd_e                     cmd;
    logic signed [ValueW-1:0] value;
    logic signed [PrioW-1:0]  prio;
    int unsigned              gap;
  } request_t;

  typedef struct packed {
    status_e                  st;
    logic signed [ValueW-1:0] value;
    logic [OccW-1:0]          occ;
  } outcome_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  cmd_e                     cmd_drv = CmdInsert;
  logic signed [ValueW-1:0] value_drv = '0;
  logic signed [PrioW-1:0]  prio_drv = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [1:0]               status;
  logic signed [ValueW-1:0] removed_value;
  logic [OccW-1:0]          occupancy;

  request_t                 req_backlog[$];
  outcome_t                 due_results[$];

  logic signed [ValueW-1:0] sh_value [CAPACITY];
  logic signed [PrioW-1:0]  sh_prio [CAPACITY];
  int unsigned              sh_count = 0;

  int unsigned              idle_left = 0;
  int unsigned              n_accepted = 0;
  int unsigned              stall_left = 0;
  int unsigned              rx_calm = 0;
  int unsigned              hold_left = 0;
  int unsigned              holds_done = 0;
  int unsigned              n_errors = 0;
  int unsigned              cycle_cnt = 0;

  sorted_priority_queue_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .cmd_i           (cmd_drv),
    .item_value_i    (value_drv),
    .item_priority_i (prio_drv),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .status_o        (status),
    .removed_value_o (removed_value),
    .occupancy_o     (occupancy)
  );

  initial forever #5 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [PrioW-1:0] pick_prio(int unsigned mode);
    if (mode == 0) return PrioW'($urandom);
    if (mode == 1) return PrioW'(int'($urandom_range(0, 6)) - 3);
    case ($urandom_range(0, 3))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      default: return 16'shFFFF;
    endcase
  endfunction

  task automatic push_req(input cmd_e op, input logic signed [ValueW-1:0] v,
                          input logic signed [PrioW-1:0] p, input int unsigned gap);
    request_t r;
    r.cmd = op;
    r.value = v;
    r.prio = p;
    r.gap = gap;
    req_backlog.push_back(r);
  endtask

  // Applies one accepted request to the shadow queue and records the result it must produce.
  task automatic shadow_apply(input cmd_e op, input logic signed [ValueW-1:0] v,
                              input logic signed [PrioW-1:0] p);
    outcome_t    res;
    int unsigned pos;
    int unsigned i;
    res.st = StInserted;
    res.value = '0;
    if (op == CmdInsert) begin
      if (sh_count >= CAPACITY) begin
        res.st = StOverflow;
      end else begin
        pos = 0;
        while (pos < sh_count && sh_prio[pos] <= p) pos++;
        for (i = sh_count; i > pos; i--) begin
          sh_value[i] = sh_value[i-1];
          sh_prio[i] = sh_prio[i-1];
        end
        sh_value[pos] = v;
        sh_prio[pos] = p;
        sh_count++;
      end
    end else if (sh_count == 0) begin
      res.st = StUnderflow;
    end else begin
      res.st = StRemoved;
      res.value = sh_value[0];
      for (i = 1; i < sh_count; i++) begin
        sh_value[i-1] = sh_value[i];
        sh_prio[i-1] = sh_prio[i];
      end
      sh_count--;
    end
    res.occ = OccW'(sh_count);
    due_results.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    request_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      idle_left <= 0;
      n_accepted <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        shadow_apply(cmd_drv, value_drv, prio_drv);
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (idle_left > 0) begin
          in_valid <= 1'b0;
          idle_left <= idle_left - 1;
        end else if (req_backlog.size() == 0) begin
          in_valid <= 1'b0;
        end else if (req_backlog[0].gap > 0) begin
          in_valid <= 1'b0;
          idle_left <= req_backlog[0].gap - 1;
          req_backlog[0].gap = 0;
        end else begin
          nxt = req_backlog.pop_front();
          in_valid <= 1'b1;
          cmd_drv <= nxt.cmd;
          value_drv <= nxt.value;
          prio_drv <= nxt.prio;
        end
      end
    end
  end

  // The receiver holds off twice for a long stretch so that the core backs up into its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      holds_done <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if ((holds_done == 0 && n_accepted >= 200) ||
                 (holds_done == 1 && n_accepted >= 600)) begin
      hold_left <= HoldCycles;
      holds_done <= holds_done + 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t    exp_r;
    int unsigned g;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      rx_calm <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          n_errors++;
          if (n_errors <= MaxShown) begin
            $display("Unexpected result: status %0d value %0d occupancy %0d",
                     status, removed_value, occupancy);
          end
        end else begin
          exp_r = due_results.pop_front();
          if (status !== exp_r.st || removed_value !== exp_r.value ||
              occupancy !== exp_r.occ) begin
            n_errors++;
            if (n_errors <= MaxShown) begin
              $display("Mismatch: expected status %0d value %0d occupancy %0d, got %0d %0d %0d",
                       exp_r.st, exp_r.value, exp_r.occ, status, removed_value, occupancy);
            end
          end
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
      end else if (rx_calm > 0) begin
        rx_calm <= rx_calm - 1;
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        g = pick_gap();
        if (g > 0) begin
          out_stall <= 1'b1;
          stall_left <= g - 1;
        end else begin
          out_stall <= 1'b0;
          if ($urandom_range(0, 99) == 0) rx_calm <= $urandom_range(30, 120);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int unsigned              n_rand;
    int unsigned              seg_len;
    int unsigned              ins_pct;
    int unsigned              prio_mode;
    int unsigned              k;
    bit                       burst;
    cmd_e                     op;
    logic signed [ValueW-1:0] v;

    // Empty removes, a full fill with ties and extremes, one overflow, then partial drain.
    push_req(CmdRemove, '0, '0, pick_gap());
    push_req(CmdRemove, '1, '1, pick_gap());
    for (k = 0; k < 16; k++) begin
      push_req(CmdInsert, DirectedInserts[k][ValueW+PrioW-1:PrioW],
               DirectedInserts[k][PrioW-1:0], pick_gap());
    end
    push_req(CmdInsert, 32'sh1234_5678, 16'sh8000, pick_gap());
    for (k = 0; k < 6; k++) push_req(CmdRemove, $urandom, PrioW'($urandom), pick_gap());

    n_rand = 0;
    while (n_rand < RandomItems) begin
      seg_len = $urandom_range(8, 60);
      case ($urandom_range(0, 4))
        0: ins_pct = 85;
        1: ins_pct = 65;
        2: ins_pct = 50;
        3: ins_pct = 35;
        default: ins_pct = 15;
      endcase
      prio_mode = $urandom_range(0, 2);
      burst = ($urandom_range(0, 4) == 0);
      for (k = 0; k < seg_len && n_rand < RandomItems; k++) begin
        op = ($urandom_range(0, 99) < ins_pct) ? CmdInsert : CmdRemove;
        if ($urandom_range(0, 15) == 0) begin
          v = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        end else begin
          v = $urandom;
        end
        push_req(op, v, pick_prio(prio_mode), burst ? 0 : pick_gap());
        n_rand++;
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (req_backlog.size() != 0 || in_valid) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
